FILE: sv/ssm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted stream merge package
// Shared types and constants for the merge sequencer and its element queues.
// ----------------------------------------------------------------------------
package ssm_pkg;

  // Default queue depth (elements held per sequence).
  localparam int unsigned QueueDepthDef = 32;

  // Width of one element value.
  localparam int unsigned ValueW = 32;

  // Stream sideband widths and bit positions.
  localparam int unsigned SUserW = 2;
  localparam int unsigned MUserW = 2;
  localparam int unsigned SUserSecondBit = 0;
  localparam int unsigned SUserEndOnlyBit = 1;
  localparam int unsigned MUserEmptyBit = 0;
  localparam int unsigned MUserOvfBit = 1;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StDecide
  } ssm_state_e;

  // Control bundle from the sequencer to one queue.
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
    logic rd_en;
  } ssm_qctrl_t;

endpackage

FILE: sv/ssm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted stream merge element queue
// Circular buffer in a memory with a registered read of the head entry.
// ----------------------------------------------------------------------------
module ssm_queue #(
  parameter int unsigned Depth = ssm_pkg::QueueDepthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ssm_pkg::ssm_qctrl_t               ctrl_i,
  input  logic [ssm_pkg::ValueW-1:0]        wr_data_i,
  output logic [$clog2(Depth+1)-1:0]        count_o,
  output logic [ssm_pkg::ValueW-1:0]        head_o
);
  import ssm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [ValueW-1:0] mem [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [ValueW-1:0] head_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (ctrl_i.clear) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      count_d  = '0;
    end else begin
      if (ctrl_i.push) begin
        wr_ptr_d = ptr_inc(wr_ptr_q);
      end
      if (ctrl_i.pop) begin
        rd_ptr_d = ptr_inc(rd_ptr_q);
      end
      if (ctrl_i.push && !ctrl_i.pop) begin
        count_d = count_q + CntW'(1);
      end else if (ctrl_i.pop && !ctrl_i.push) begin
        count_d = count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      head_q <= mem[rd_ptr_q];
    end
  end

  assign count_o = count_q;
  assign head_o  = head_q;

endmodule

FILE: sv/sorted_stream_merge_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted stream merge
// Merges two ascending streams of signed 32-bit values into one ascending
// stream, with a final marked result and a sticky overflow flag.
// ----------------------------------------------------------------------------
// Each input transaction carries an element of the first or second sequence
// (s_tuser_i bit 0), an end mark on s_tlast_i, or only an end mark when
// s_tuser_i bit 1 is set. Elements are held in one queue per sequence of
// QUEUE_DEPTH entries; an element arriving at a full queue is dropped and the
// overflow flag in m_tuser_o is raised until the merge finishes. Results come
// out in ascending order, ties going to the second sequence, and the last one
// carries m_tlast_o; when both sequences are empty a single result flagged
// empty is given. Once the other sequence has ended and drained, one element
// is held back until its own sequence has ended so that the final result can
// be marked. An input transaction is taken only while the sequencer is idle
// and passes through accept, head read and decision when it causes no result;
// every result then adds a read of the queue heads from memory and a decision
// in which the shared comparator picks and pops it. The decision that gives
// the final result of a merge, or the empty result, also ends the transaction,
// so that closing head read and decision are not spent again. The sequencer
// waits in its decision step while the output register is still full, and a
// new input is accepted while a finished result waits to be taken. After the
// final result both queues and all flags clear themselves in the same cycle,
// ready for the next merge.
// ----------------------------------------------------------------------------
module sorted_stream_merge_top #(
  parameter int unsigned QUEUE_DEPTH = ssm_pkg::QueueDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [ssm_pkg::ValueW-1:0]  s_tdata_i,  // [31:0] value
  input  logic                        s_tlast_i,  // last_of_list
  input  logic [ssm_pkg::SUserW-1:0]  s_tuser_i,  // [0] from_second_list, [1] end_only
  // Output stream
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [ssm_pkg::ValueW-1:0]  m_tdata_o,  // [31:0] merged_value
  output logic                        m_tlast_o,  // merge_last
  output logic [ssm_pkg::MUserW-1:0]  m_tuser_o   // [0] merge_empty, [1] overflowed
);
  import ssm_pkg::*;

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  ssm_state_e state_q, state_d;

  logic ended_f_q, ended_f_d;
  logic ended_s_q, ended_s_d;
  logic ovf_q, ovf_d;

  ssm_qctrl_t    qctrl_f, qctrl_s;
  logic [CntW-1:0]   cnt_f, cnt_s;
  logic [ValueW-1:0] head_f, head_s;

  // Output register.
  logic              m_valid_q;
  logic [ValueW-1:0] out_data_q;
  logic              out_last_q, out_empty_q, out_ovf_q;

  logic              load;
  logic [ValueW-1:0] load_data;
  logic              load_last, load_empty;
  logic              out_free;

  logic s_accept;
  logic in_second, in_end_only;

  ssm_queue #(.Depth(QUEUE_DEPTH)) u_queue_first (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (qctrl_f),
    .wr_data_i (s_tdata_i),
    .count_o   (cnt_f),
    .head_o    (head_f)
  );

  ssm_queue #(.Depth(QUEUE_DEPTH)) u_queue_second (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (qctrl_s),
    .wr_data_i (s_tdata_i),
    .count_o   (cnt_s),
    .head_o    (head_s)
  );

  assign s_tready_o  = (state_q == StIdle);
  assign s_accept    = s_tvalid_i && s_tready_o;
  assign in_second   = s_tuser_i[SUserSecondBit];
  assign in_end_only = s_tuser_i[SUserEndOnlyBit];
  assign out_free    = !m_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ended_f_q <= 1'b0;
      ended_s_q <= 1'b0;
      ovf_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      ended_f_q <= ended_f_d;
      ended_s_q <= ended_s_d;
      ovf_q     <= ovf_d;
    end
  end

  // Sequencer: takes one input, then loops reading the queue heads and
  // emitting the winner of the shared compare until nothing more may go out.
  always_comb begin
    logic take_second;
    logic pop_f, pop_s;
    logic done;

    state_d    = state_q;
    ended_f_d  = ended_f_q;
    ended_s_d  = ended_s_q;
    ovf_d      = ovf_q;
    qctrl_f    = '0;
    qctrl_s    = '0;
    load       = 1'b0;
    load_data  = '0;
    load_last  = 1'b0;
    load_empty = 1'b0;
    pop_f      = 1'b0;
    pop_s      = 1'b0;
    done       = 1'b0;

    // The one comparator of the block: ties favour the second sequence.
    take_second = ($signed(head_s) <= $signed(head_f));

    case (state_q)
      StIdle: begin
        if (s_accept) begin
          state_d = StRead;
          // Items for a sequence that has already ended are ignored entirely.
          if (in_second && !ended_s_q) begin
            if (!in_end_only) begin
              if (cnt_s == CntW'(QUEUE_DEPTH)) begin
                ovf_d = 1'b1;
              end else begin
                qctrl_s.push = 1'b1;
              end
            end
            if (s_tlast_i) begin
              ended_s_d = 1'b1;
            end
          end else if (!in_second && !ended_f_q) begin
            if (!in_end_only) begin
              if (cnt_f == CntW'(QUEUE_DEPTH)) begin
                ovf_d = 1'b1;
              end else begin
                qctrl_f.push = 1'b1;
              end
            end
            if (s_tlast_i) begin
              ended_f_d = 1'b1;
            end
          end
        end
      end

      StRead: begin
        qctrl_f.rd_en = 1'b1;
        qctrl_s.rd_en = 1'b1;
        state_d       = StDecide;
      end

      StDecide: begin
        if (ended_f_q && ended_s_q && cnt_f == '0 && cnt_s == '0) begin
          // Both sequences empty.
          load       = 1'b1;
          load_last  = 1'b1;
          load_empty = 1'b1;
        end else if (cnt_f != '0 && cnt_s != '0) begin
          load  = 1'b1;
          pop_s = take_second;
          pop_f = !take_second;
        end else if (cnt_f == '0 && ended_f_q && cnt_s != '0) begin
          if (ended_s_q) begin
            load      = 1'b1;
            pop_s     = 1'b1;
            load_last = (cnt_s == CntW'(1));
          end else if (cnt_s >= CntW'(2)) begin
            load  = 1'b1;
            pop_s = 1'b1;
          end
        end else if (cnt_s == '0 && ended_s_q && cnt_f != '0) begin
          if (ended_f_q) begin
            load      = 1'b1;
            pop_f     = 1'b1;
            load_last = (cnt_f == CntW'(1));
          end else if (cnt_f >= CntW'(2)) begin
            load  = 1'b1;
            pop_f = 1'b1;
          end
        end

        load_data = pop_s ? head_s : (pop_f ? head_f : '0);

        if (!load) begin
          state_d = StIdle;
        end else if (!out_free) begin
          // Hold the decision until the output register can take it.
          load  = 1'b0;
          pop_f = 1'b0;
          pop_s = 1'b0;
        end else begin
          done = load_last;
          if (done) begin
            state_d = StIdle;
          end else begin
            state_d = StRead;
          end
        end

        qctrl_f.pop = pop_f;
        qctrl_s.pop = pop_s;
        if (done) begin
          qctrl_f.clear = 1'b1;
          qctrl_s.clear = 1'b1;
          ended_f_d     = 1'b0;
          ended_s_d     = 1'b0;
          ovf_d         = 1'b0;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q  <= load_data;
      out_last_q  <= load_last;
      out_empty_q <= load_empty;
      out_ovf_q   <= ovf_q;
    end
  end

  assign m_tvalid_o              = m_valid_q;
  assign m_tdata_o               = out_data_q;
  assign m_tlast_o               = out_last_q;
  assign m_tuser_o[MUserEmptyBit] = out_empty_q;
  assign m_tuser_o[MUserOvfBit]   = out_ovf_q;

  // Queues never hold more than their depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_f <= CntW'(QUEUE_DEPTH)) && (cnt_s <= CntW'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

  // A result is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && m_valid_q) |-> m_tready_i)
    else $error("output register overwritten");

  // The final result leaves the block cleared for the next merge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && load_last) |=> (cnt_f == '0 && cnt_s == '0 && !ended_f_q && !ended_s_q && !ovf_q))
    else $error("merge state not cleared after final result");

  // An empty result is only given when both queues are empty and both ended.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && load_empty) |-> (cnt_f == '0 && cnt_s == '0 && ended_f_q && ended_s_q))
    else $error("empty result with elements pending");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted stream merge testbench
// Feeds merges of two signed sequences through the input stream, works out
// the merged results for every accepted transaction and compares them, field
// by field and in order, with what the output stream delivers. Both sides
// idle at random, and once the output is held off long enough for the block
// to fill and stall its input.
// ----------------------------------------------------------------------------
module tb_top;
  import ssm_pkg::*;

  localparam int unsigned QueueDepth = QueueDepthDef;
  localparam logic signed [ValueW-1:0] MinValue = 32'sh8000_0000;
  localparam logic signed [ValueW-1:0] MaxValue = 32'sh7FFF_FFFF;
  localparam int RandomItems = 210;
  localparam int HoldOffCycles = 400;

  typedef struct packed {
    logic                     second;
    logic signed [ValueW-1:0] value;
    logic                     mark;
    logic                     end_only;
  } merge_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last;
    logic                     empty;
    logic                     ovf;
  } merged_beat_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [ValueW-1:0] s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic [SUserW-1:0] s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [ValueW-1:0] m_tdata;
  logic              m_tlast;
  logic [MUserW-1:0] m_tuser;

  // Predicted contents of the two element queues and the merge flags.
  logic signed [ValueW-1:0] held_first[$];
  logic signed [ValueW-1:0] held_second[$];
  logic ended_first = 1'b0;
  logic ended_second = 1'b0;
  logic ovf_seen = 1'b0;

  merged_beat_t merged_due[$];
  merge_item_t  pending_items[$];
  merge_item_t  on_bus;
  logic signed [ValueW-1:0] vals_first[$];
  logic signed [ValueW-1:0] vals_second[$];

  logic item_taken = 1'b0;
  logic hold_out = 1'b0;
  logic send_calm = 1'b0;
  logic recv_calm = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   accepted_cnt = 0;
  int   errors = 0;

  sorted_stream_merge_top #(
    .QUEUE_DEPTH(QueueDepth)
  ) u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .s_tvalid_i(s_tvalid),
    .s_tready_o(s_tready),
    .s_tdata_i (s_tdata),
    .s_tlast_i (s_tlast),
    .s_tuser_i (s_tuser),
    .m_tvalid_o(m_tvalid),
    .m_tready_i(m_tready),
    .m_tdata_o (m_tdata),
    .m_tlast_o (m_tlast),
    .m_tuser_o (m_tuser)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $realtime, what);
    errors++;
  endtask

  task automatic clear_merge_state();
    held_first.delete();
    held_second.delete();
    ended_first = 1'b0;
    ended_second = 1'b0;
    ovf_seen = 1'b0;
  endtask

  task automatic push_beat(input logic signed [ValueW-1:0] value, input logic last,
                           input logic empty);
    merged_beat_t beat;
    beat.value = value;
    beat.last = last;
    beat.empty = empty;
    beat.ovf = ovf_seen;
    merged_due.push_back(beat);
  endtask

  // Works out the results that one accepted transaction releases.
  task automatic merge_predict(input merge_item_t it);
    logic signed [ValueW-1:0] v;
    logic last;
    logic take;
    logic done;
    if (!(it.second ? ended_second : ended_first)) begin
      if (!it.end_only) begin
        if (it.second) begin
          if (held_second.size() >= QueueDepth) ovf_seen = 1'b1;
          else held_second.push_back(it.value);
        end else begin
          if (held_first.size() >= QueueDepth) ovf_seen = 1'b1;
          else held_first.push_back(it.value);
        end
      end
      if (it.mark) begin
        if (it.second) ended_second = 1'b1;
        else ended_first = 1'b1;
      end
    end
    if (ended_first && ended_second && held_first.size() == 0 && held_second.size() == 0) begin
      push_beat('0, 1'b1, 1'b1);
      clear_merge_state();
      return;
    end
    done = 1'b0;
    while (!done) begin
      last = 1'b0;
      take = 1'b1;
      v = '0;
      if (held_first.size() > 0 && held_second.size() > 0) begin
        // Ties go to the second sequence.
        if (held_second[0] <= held_first[0]) v = held_second.pop_front();
        else v = held_first.pop_front();
      end else if (held_first.size() == 0 && ended_first && held_second.size() > 0) begin
        if (ended_second) begin
          v = held_second.pop_front();
          last = (held_second.size() == 0);
        end else if (held_second.size() >= 2) begin
          v = held_second.pop_front();
        end else begin
          take = 1'b0;
        end
      end else if (held_second.size() == 0 && ended_second && held_first.size() > 0) begin
        if (ended_first) begin
          v = held_first.pop_front();
          last = (held_first.size() == 0);
        end else if (held_first.size() >= 2) begin
          v = held_first.pop_front();
        end else begin
          take = 1'b0;
        end
      end else begin
        take = 1'b0;
      end
      if (!take) begin
        done = 1'b1;
      end else begin
        push_beat(v, last, 1'b0);
        if (last) begin
          clear_merge_state();
          done = 1'b1;
        end
      end
    end
  endtask

  // Mostly short gaps, now and then a long one; none in a calm stretch.
  function automatic int idle_len(input logic calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [ValueW-1:0] pick_value(input int shape);
    case (shape)
      0: return $urandom();
      1: return $urandom_range(0, 8) - 4;
      default: begin
        case ($urandom_range(0, 6))
          0: return MinValue;
          1: return MinValue + 1;
          2: return -1;
          3: return 0;
          4: return 1;
          5: return MaxValue - 1;
          default: return MaxValue;
        endcase
      end
    endcase
  endfunction

  task automatic push_item(input logic second, input logic signed [ValueW-1:0] value,
                           input logic mark, input logic end_only);
    merge_item_t it;
    it.second = second;
    it.value = value;
    it.mark = mark;
    it.end_only = end_only;
    pending_items.push_back(it);
  endtask

  // Fills one sequence with values, ascending unless the sequence is broken.
  task automatic make_values(input logic second, input int len, input int shape,
                             input logic unsorted);
    logic signed [ValueW-1:0] tmp[$];
    logic signed [ValueW-1:0] v;
    int k;
    for (int i = 0; i < len; i++) begin
      v = pick_value(shape);
      k = tmp.size();
      if (!unsorted) begin
        while (k > 0 && tmp[k-1] > v) k--;
      end
      tmp.insert(k, v);
    end
    if (second) vals_second = tmp;
    else vals_first = tmp;
  endtask

  function automatic int list_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 85) return $urandom_range(1, 6);
    return $urandom_range(7, 20);
  endfunction

  // One merge: two sequences interleaved at random, with a little noise.
  task automatic gen_merge(output int counted);
    int len_a, len_b, bias, ia, ib;
    logic sep_a, sep_b, done_a, done_b, pick_b, noise_b;
    counted = 0;
    if ($urandom_range(0, 11) == 0) begin
      // One sequence arrives wholesale and overruns its queue.
      if ($urandom_range(0, 1) == 0) begin
        len_a = $urandom_range(QueueDepth + 1, QueueDepth + 4);
        len_b = $urandom_range(0, 2);
        bias = 0;
      end else begin
        len_b = $urandom_range(QueueDepth + 1, QueueDepth + 4);
        len_a = $urandom_range(0, 2);
        bias = 100;
      end
    end else begin
      len_a = list_len();
      len_b = list_len();
      bias = $urandom_range(0, 4) * 25;
    end
    make_values(1'b0, len_a, $urandom_range(0, 2), $urandom_range(0, 9) == 0);
    make_values(1'b1, len_b, $urandom_range(0, 2), $urandom_range(0, 9) == 0);
    sep_a = (len_a == 0) || ($urandom_range(0, 2) == 0);
    sep_b = (len_b == 0) || ($urandom_range(0, 2) == 0);
    ia = 0;
    ib = 0;
    done_a = 1'b0;
    done_b = 1'b0;
    while (!(done_a && done_b)) begin
      if ($urandom_range(0, 14) == 0) begin
        if (done_a || done_b) begin
          // The other sequence is still open, so this is ignored.
          push_item(done_b, $urandom(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end else begin
          noise_b = 1'($urandom_range(0, 1));
          push_item(noise_b, $urandom(), 1'b0, 1'b1);
        end
        counted++;
      end
      pick_b = done_a ? 1'b1 : done_b ? 1'b0 : ($urandom_range(0, 99) < bias);
      if (pick_b) begin
        if (ib < len_b) begin
          push_item(1'b1, vals_second[ib], (ib == len_b - 1) && !sep_b, 1'b0);
          ib++;
          done_b = (ib == len_b) && !sep_b;
        end else begin
          push_item(1'b1, $urandom(), 1'b1, 1'b1);
          done_b = 1'b1;
        end
      end else begin
        if (ia < len_a) begin
          push_item(1'b0, vals_first[ia], (ia == len_a - 1) && !sep_a, 1'b0);
          ia++;
          done_a = (ia == len_a) && !sep_a;
        end else begin
          push_item(1'b0, $urandom(), 1'b1, 1'b1);
          done_a = 1'b1;
        end
      end
      counted++;
    end
  endtask

  // Sender: a new transaction is put up at the falling edge once the last
  // one has gone, after an optional gap.
  always @(negedge clk) begin : p_driver
    logic [SUserW-1:0] user_v;
    if (rst_n && (!s_tvalid || item_taken)) begin
      item_taken = 1'b0;
      if (send_gap > 0) begin
        s_tvalid <= 1'b0;
        send_gap--;
      end else if (pending_items.size() > 0) begin
        on_bus = pending_items.pop_front();
        user_v = '0;
        user_v[SUserSecondBit] = on_bus.second;
        user_v[SUserEndOnlyBit] = on_bus.end_only;
        s_tdata <= on_bus.value;
        s_tlast <= on_bus.mark;
        s_tuser <= user_v;
        s_tvalid <= 1'b1;
        // Keep offering without gaps while the output is held off.
        send_gap = hold_out ? 0 : idle_len(send_calm);
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when asked for.
  always @(negedge clk) begin : p_receiver
    if (!rst_n || hold_out) begin
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      m_tready <= 1'b0;
      recv_gap--;
    end else begin
      m_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_gap = idle_len(recv_calm);
      if ($urandom_range(0, 199) == 0) recv_calm = !recv_calm;
    end
  end

  // Predicts on every input transaction and checks every output transaction.
  always @(posedge clk) begin : p_monitor
    merged_beat_t want;
    if (rst_n) begin
      if (s_tvalid && s_tready) begin
        merge_predict(on_bus);
        item_taken = 1'b1;
        accepted_cnt++;
      end
      if (m_tvalid && m_tready) begin
        if (merged_due.size() == 0) begin
          report_mismatch($sformatf("result %0h with nothing expected", m_tdata));
        end else begin
          want = merged_due.pop_front();
          if (m_tdata !== want.value)
            report_mismatch($sformatf("merged_value %0h, expected %0h", m_tdata, want.value));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("merge_last %0b, expected %0b", m_tlast, want.last));
          if (m_tuser[MUserEmptyBit] !== want.empty)
            report_mismatch($sformatf("merge_empty %0b, expected %0b",
                                      m_tuser[MUserEmptyBit], want.empty));
          if (m_tuser[MUserOvfBit] !== want.ovf)
            report_mismatch($sformatf("overflowed %0b, expected %0b",
                                      m_tuser[MUserOvfBit], want.ovf));
        end
      end
    end
  end

  // Long output hold-off so that the queues fill and the input stalls.
  initial begin : p_pressure
    wait (accepted_cnt >= 60);
    @(posedge clk);
    hold_out = 1'b1;
    repeat (HoldOffCycles) @(posedge clk);
    hold_out = 1'b0;
  end

  initial begin : p_watchdog
    #16_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : p_main
    int n;
    int rand_count;
    // Both sequences empty; the second end mark carries an all-ones value.
    push_item(1'b0, '0, 1'b1, 1'b1);
    push_item(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // An end-only transaction without the mark does nothing.
    push_item(1'b0, 123, 1'b0, 1'b1);
    // Extremes, a tie at the minimum, element and mark together, an item for
    // a sequence that has ended, and an end mark on its own.
    push_item(1'b0, MinValue, 1'b0, 1'b0);
    push_item(1'b1, MinValue, 1'b0, 1'b0);
    push_item(1'b0, MaxValue, 1'b1, 1'b0);
    push_item(1'b0, 5, 1'b1, 1'b0);
    push_item(1'b1, -1, 1'b0, 1'b0);
    push_item(1'b1, 0, 1'b1, 1'b1);
    // Equal values on both sides.
    push_item(1'b0, 7, 1'b0, 1'b0);
    push_item(1'b0, 7, 1'b1, 1'b0);
    push_item(1'b1, 7, 1'b0, 1'b0);
    push_item(1'b1, 7, 1'b1, 1'b0);
    // First sequence empty, second drains.
    push_item(1'b0, 0, 1'b1, 1'b1);
    push_item(1'b1, 1, 1'b0, 1'b0);
    push_item(1'b1, 2, 1'b0, 1'b0);
    push_item(1'b1, 3, 1'b1, 1'b0);
    // A single element on each side.
    push_item(1'b1, -5, 1'b1, 1'b0);
    push_item(1'b0, 9, 1'b1, 1'b0);
    // Alternating bit patterns.
    push_item(1'b0, 32'h5555_5555, 1'b0, 1'b0);
    push_item(1'b1, 32'hAAAA_AAAA, 1'b1, 1'b0);
    push_item(1'b0, MaxValue, 1'b1, 1'b0);

    rand_count = pending_items.size();
    while (rand_count < RandomItems) begin
      gen_merge(n);
      rand_count += n;
    end

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || s_tvalid) @(posedge clk);
    while (merged_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/ssm_pkg.sv
sv/ssm_queue.sv
sv/sorted_stream_merge_top.sv
tb/tb_top.sv
